// ===== hdl/polyline_winding_contribution_assert.svh =====
// assertion macros used by the checker of this block
`ifndef POLYLINE_WINDING_CONTRIBUTION_ASSERT_SVH
`define POLYLINE_WINDING_CONTRIBUTION_ASSERT_SVH

// property checked while reset is low
`define PWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define PWC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/pwc_pkg.sv =====
`default_nettype none

package pwc_pkg;

   localparam int COORD_BITS = 24;
   localparam int SUM_BITS   = 17;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CSR_BITS   = 1;

   localparam logic [CSR_BITS-1:0] CSR_POINT_X = CSR_BITS'(0);
   localparam logic [CSR_BITS-1:0] CSR_POINT_Y = CSR_BITS'(1);

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = -SUM_MAX;

   typedef struct packed {
      logic count;
      logic step_neg;
      logic both_below;
      logic mixed;
      logic last;
      logic fwd;
   } seg_type;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] rx;
      logic signed [DIFF_BITS-1:0] ry;
      logic signed [DIFF_BITS-1:0] dx;
      logic signed [DIFF_BITS-1:0] dy;
   } diff_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] p;
      logic signed [PROD_BITS-1:0] q;
      logic                        dx_neg;
      logic                        dx_pos;
   } prod_type;

endpackage

`default_nettype wire

// ===== hdl/pwc_segment_front.sv =====
`default_nettype none

module pwc_segment_front
   import pwc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         req_valid,
   input  wire logic signed [COORD_BITS-1:0] req_sample_x,
   input  wire logic signed [COORD_BITS-1:0] req_sample_y,
   input  wire logic                         req_forward,
   input  wire logic                         req_last_sample,
   input  wire logic                         csr_write,
   input  wire logic        [CSR_BITS-1:0]   csr_index,
   input  wire logic        [COORD_BITS-1:0] csr_data,
   output logic                              a_valid,
   output seg_type                           a_seg,
   output diff_type                          a_diff
);

   logic signed [COORD_BITS-1:0] point_x_ff;
   logic signed [COORD_BITS-1:0] point_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff;
   logic signed [COORD_BITS-1:0] prev_y_ff;
   logic                         prev_left_ff;
   logic                         awaiting_first_ff;
   logic                         a_valid_ff;
   seg_type                      a_seg_ff;
   seg_type                      a_seg_in;
   diff_type                     a_diff_ff;
   diff_type                     a_diff_in;
   logic                         accept;
   logic                         x_left;
   logic                         above_i;
   logic                         above_j;

   assign accept  = req_valid && advance;
   assign x_left  = req_sample_x <= point_x_ff;
   assign above_i = prev_y_ff < point_y_ff;
   assign above_j = req_sample_y < point_y_ff;

   always_comb begin
      a_seg_in.count      = !awaiting_first_ff && (x_left != prev_left_ff);
      a_seg_in.step_neg   = prev_left_ff;
      a_seg_in.both_below = !above_i && !above_j;
      a_seg_in.mixed      = above_i != above_j;
      a_seg_in.last       = req_last_sample;
      a_seg_in.fwd        = req_forward;
      a_diff_in.rx = {prev_x_ff[COORD_BITS-1], prev_x_ff}
                   - {point_x_ff[COORD_BITS-1], point_x_ff};
      a_diff_in.ry = {prev_y_ff[COORD_BITS-1], prev_y_ff}
                   - {point_y_ff[COORD_BITS-1], point_y_ff};
      a_diff_in.dx = {req_sample_x[COORD_BITS-1], req_sample_x}
                   - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      a_diff_in.dy = {req_sample_y[COORD_BITS-1], req_sample_y}
                   - {prev_y_ff[COORD_BITS-1], prev_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff <= '0;
         point_y_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_POINT_X) begin
            point_x_ff <= csr_data;
         end else begin
            point_y_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff         <= '0;
         prev_y_ff         <= '0;
         prev_left_ff      <= 1'b0;
         awaiting_first_ff <= 1'b1;
         a_valid_ff        <= 1'b0;
      end else begin
         if (advance) begin
            a_valid_ff <= req_valid;
         end
         if (accept) begin
            prev_x_ff         <= req_sample_x;
            prev_y_ff         <= req_sample_y;
            prev_left_ff      <= x_left;
            awaiting_first_ff <= req_last_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_seg_ff  <= a_seg_in;
         a_diff_ff <= a_diff_in;
      end
   end

   assign a_valid = a_valid_ff;
   assign a_seg   = a_seg_ff;
   assign a_diff  = a_diff_ff;

endmodule

`default_nettype wire

// ===== hdl/pwc_cross_mult.sv =====
`default_nettype none

module pwc_cross_mult
   import pwc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     a_valid,
   input  wire seg_type  a_seg,
   input  wire diff_type a_diff,
   output logic          b_valid,
   output seg_type       b_seg,
   output prod_type      b_prod
);

   logic     b_valid_ff;
   seg_type  b_seg_ff;
   prod_type b_prod_ff;
   prod_type b_prod_in;

   always_comb begin
      b_prod_in.p      = $signed(a_diff.rx) * $signed(a_diff.dy);
      b_prod_in.q      = $signed(a_diff.ry) * $signed(a_diff.dx);
      b_prod_in.dx_neg = a_diff.dx[DIFF_BITS-1];
      b_prod_in.dx_pos = !a_diff.dx[DIFF_BITS-1] && (a_diff.dx != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_valid) begin
         b_seg_ff  <= a_seg;
         b_prod_ff <= b_prod_in;
      end
   end

   assign b_valid = b_valid_ff;
   assign b_seg   = b_seg_ff;
   assign b_prod  = b_prod_ff;

endmodule

`default_nettype wire

// ===== hdl/pwc_accumulate.sv =====
`default_nettype none

module pwc_accumulate
   import pwc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   b_valid,
   input  wire seg_type                b_seg,
   input  wire prod_type               b_prod,
   input  wire logic                   rsp_stall,
   output logic                        advance,
   output logic                        rsp_valid,
   output logic signed [SUM_BITS-1:0]  rsp_winding_contribution
);

   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] out_ff;
   logic                       out_valid_ff;
   logic                       crosses;
   logic                       take_step;

   assign advance = !out_valid_ff || !rsp_stall;

   // sign of the cross product against the direction of the segment in x
   assign crosses = ((b_prod.p > b_prod.q) && b_prod.dx_neg)
                 || ((b_prod.p < b_prod.q) && b_prod.dx_pos);
   assign take_step = b_seg.count && (b_seg.both_below || (b_seg.mixed && crosses));

   always_comb begin
      sum_in = sum_ff;
      if (take_step) begin
         if (b_seg.step_neg) begin
            if (sum_ff != SUM_MIN) begin
               sum_in = sum_ff - SUM_BITS'(1);
            end
         end else begin
            if (sum_ff != SUM_MAX) begin
               sum_in = sum_ff + SUM_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= b_valid && b_seg.last;
         if (b_valid) begin
            sum_ff <= b_seg.last ? '0 : sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && b_valid && b_seg.last) begin
         out_ff <= b_seg.fwd ? sum_in : -sum_in;
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_winding_contribution = out_ff;

endmodule

`default_nettype wire

// ===== hdl/polyline_winding_contribution.sv =====
// Winding contribution of one polyline about the query point (point_x, point_y), written at
// csr index 0 and 1. Samples arrive one request per cycle while req_stall is low, with no
// bubbles needed; rsp_valid rises once the request carrying last_sample has passed through
// a difference register, a register after the two 25 by 25 bit cross-product multipliers,
// and the result register beside the accumulator. A stalled result holds the whole
// pipeline, and requests stall once the two stages behind it are full. Point registers are
// to be written by the user only while no request is in flight; the block does not enforce
// this. A write inside a polyline applies from the next segment on.
`default_nettype none

module polyline_winding_contribution
   import pwc_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_sample_x,
   input  wire logic signed [COORD_BITS-1:0] req_sample_y,
   input  wire logic                         req_forward,
   input  wire logic                         req_last_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [SUM_BITS-1:0]        rsp_winding_contribution,
   input  wire logic                         csr_write,
   input  wire logic        [CSR_BITS-1:0]   csr_index,
   input  wire logic        [COORD_BITS-1:0] csr_data
);

   logic     a_valid;
   seg_type  a_seg;
   diff_type a_diff;
   logic     b_valid;
   seg_type  b_seg;
   prod_type b_prod;
   logic     adv_a;
   logic     adv_b;
   logic     adv_c;

   assign adv_b     = !b_valid || adv_c;
   assign adv_a     = !a_valid || adv_b;
   assign req_stall = !adv_a;

   pwc_segment_front u_front (
      .clock           (clock),
      .reset           (reset),
      .advance         (adv_a),
      .req_valid       (req_valid),
      .req_sample_x    (req_sample_x),
      .req_sample_y    (req_sample_y),
      .req_forward     (req_forward),
      .req_last_sample (req_last_sample),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .a_valid         (a_valid),
      .a_seg           (a_seg),
      .a_diff          (a_diff)
   );

   pwc_cross_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .advance (adv_b),
      .a_valid (a_valid),
      .a_seg   (a_seg),
      .a_diff  (a_diff),
      .b_valid (b_valid),
      .b_seg   (b_seg),
      .b_prod  (b_prod)
   );

   pwc_accumulate u_acc (
      .clock                    (clock),
      .reset                    (reset),
      .b_valid                  (b_valid),
      .b_seg                    (b_seg),
      .b_prod                   (b_prod),
      .rsp_stall                (rsp_stall),
      .advance                  (adv_c),
      .rsp_valid                (rsp_valid),
      .rsp_winding_contribution (rsp_winding_contribution)
   );

endmodule

`default_nettype wire

// ===== hdl/pwc_checker.sv =====
`default_nettype none
`include "polyline_winding_contribution_assert.svh"

module pwc_checker
   import pwc_pkg::*;
(
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic signed [SUM_BITS-1:0]   rsp_winding_contribution
);

   localparam logic [SUM_BITS-1:0] MOST_NEG = {1'b1, {(SUM_BITS-1){1'b0}}};

   `PWC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   `PWC_ASSERT(a_stall_only_behind_result, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "request stalled with no stalled result")

   `PWC_ASSERT(a_saturated_range, clock, reset, rsp_valid |-> (rsp_winding_contribution != MOST_NEG), "result outside symmetric range")

   `PWC_ASSERT(a_valid_holds, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped while stalled")

   `PWC_ASSERT(a_payload_holds, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_winding_contribution), "stalled result changed")

endmodule

bind polyline_winding_contribution pwc_checker u_pwc_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_stall                (req_stall),
   .rsp_valid                (rsp_valid),
   .rsp_stall                (rsp_stall),
   .rsp_winding_contribution (rsp_winding_contribution)
);

`default_nettype wire
